FILE: rtl/core/atd_pkg.sv
package atd_pkg;

   localparam int MAX_TRIGGERS = 64;
   localparam int SINE_ENTRIES = 1024;
   localparam int SLOT_W = $clog2(MAX_TRIGGERS);
   localparam int SINE_W = $clog2(SINE_ENTRIES);
   localparam int RESULT_CAP = 64;
   localparam int CNT_W = $clog2(RESULT_CAP + 1);
   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [1:0] KIND_SPHERE = 2'd1;
   localparam logic [1:0] KIND_BOX = 2'd2;

   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD = 2'd1,
      CMD_CHECK = 2'd2,
      CMD_NOP = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD = 2'd1,
      OP_NOP = 2'd2,
      OP_SLOT = 2'd3
   } op_type;

   typedef enum logic {
      FS_IDLE = 1'b0,
      FS_SCAN = 1'b1
   } front_state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [5:0] slot;
      logic [31:0] trigger_id;
      logic [31:0] map_id;
      logic [1:0] kind;
      logic signed [23:0] coord_x;
      logic signed [23:0] coord_y;
      logic signed [23:0] coord_z;
      logic [22:0] extent_x;
      logic [22:0] extent_y;
      logic [22:0] extent_z;
      logic signed [15:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic [31:0] entered_id;
      logic found;
      logic load_ignored;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [1:0] kind;
      logic signed [23:0] center_x;
      logic signed [23:0] center_y;
      logic signed [23:0] center_z;
      logic [22:0] size_x;
      logic [22:0] size_y;
      logic [22:0] size_z;
      logic [15:0] yaw;
   } entry_type;

   // one unit of work travelling from the front through the queue to the back
   typedef struct packed {
      op_type op;
      logic [SLOT_W-1:0] slot;
      logic ign;
      logic hit;
      logic fin;
      logic [31:0] id;
   } job_type;

   typedef logic signed [15:0] sine_rom_type [SINE_ENTRIES];

   // Q1.14 sine table from a Q30 Taylor series, evaluated at elaboration
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint unsigned a;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned t;
      longint unsigned sr;
      longint s;
      logic neg;
      int k;
      int n;
      for (k = 0; k < SINE_ENTRIES; k++) begin
         a = (TWO_PI_Q30 * 64'(k)) >> SINE_W;
         neg = 1'b0;
         if (a >= PI_Q30) begin
            a = a - PI_Q30;
            neg = 1'b1;
         end
         if (a > HALF_PI_Q30) begin
            a = PI_Q30 - a;
         end
         x2 = (a * a) >> 30;
         term = a;
         s = longint'(a);
         for (n = 1; n <= 7; n++) begin
            t = (term * x2) >> 30;
            case (n)
               1: term = t / 64'd6;
               2: term = t / 64'd20;
               3: term = t / 64'd42;
               4: term = t / 64'd72;
               5: term = t / 64'd110;
               6: term = t / 64'd156;
               default: term = t / 64'd210;
            endcase
            if ((n % 2) == 1) begin
               s = s - longint'(term);
            end else begin
               s = s + longint'(term);
            end
         end
         if (s < 0) begin
            s = 0;
         end
         sr = (64'(s) + 64'd32768) >> 16;
         rom[k] = neg ? -16'(sr) : 16'(sr);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/core/atd_ram.sv
module atd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0] write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

FILE: rtl/core/atd_front.sv
module atd_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  atd_pkg::req_type req_data,
   input  logic [31:0] active_map,
   input  logic pop,
   output logic tag_valid,
   output atd_pkg::job_type tag,
   output atd_pkg::entry_type entry,
   output logic signed [23:0] point_x,
   output logic signed [23:0] point_y,
   output logic signed [23:0] point_z
);

   atd_pkg::front_state_type state_ff, state_in;
   logic [atd_pkg::SLOT_W-1:0] scan_ff;
   logic [atd_pkg::QCNT_W-1:0] outstanding_ff;
   logic [atd_pkg::MAX_TRIGGERS-1:0] valid_ff;
   logic tag_valid_ff;
   atd_pkg::job_type tag_ff, tag_in;
   logic signed [23:0] point_x_ff, point_y_ff, point_z_ff;
   logic issue_ok, accept, issue, map_ok, slot_ok, write_en, scan_last;
   atd_pkg::cmd_type cmd;
   atd_pkg::entry_type entry_w;
   logic [atd_pkg::SLOT_W-1:0] load_slot;

   assign cmd = atd_pkg::cmd_type'(req_data.command);
   assign issue_ok = outstanding_ff < atd_pkg::QCNT_W'(atd_pkg::QDEPTH);
   assign req_ready = (state_ff == atd_pkg::FS_IDLE) && issue_ok;
   assign accept = req_valid && req_ready;
   assign map_ok = req_data.map_id == active_map;
   assign slot_ok = {26'd0, req_data.slot} < 32'(atd_pkg::MAX_TRIGGERS);
   assign write_en = accept && (cmd == atd_pkg::CMD_LOAD) && map_ok && slot_ok;
   assign scan_last = scan_ff == atd_pkg::SLOT_W'(atd_pkg::MAX_TRIGGERS - 1);
   assign load_slot = atd_pkg::SLOT_W'(req_data.slot);

   always_comb begin
      entry_w.id = req_data.trigger_id;
      entry_w.kind = req_data.kind;
      entry_w.center_x = req_data.coord_x;
      entry_w.center_y = req_data.coord_y;
      entry_w.center_z = req_data.coord_z;
      entry_w.size_x = req_data.extent_x;
      entry_w.size_y = req_data.extent_y;
      entry_w.size_z = req_data.extent_z;
      entry_w.yaw = req_data.yaw_angle;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         atd_pkg::FS_IDLE: begin
            if (accept && (cmd == atd_pkg::CMD_CHECK)) begin
               state_in = atd_pkg::FS_SCAN;
            end
         end
         atd_pkg::FS_SCAN: begin
            if (issue_ok && scan_last) begin
               state_in = atd_pkg::FS_IDLE;
            end
         end
         default: state_in = atd_pkg::FS_IDLE;
      endcase
   end

   always_comb begin
      issue = 1'b0;
      tag_in = '0;
      unique case (state_ff)
         atd_pkg::FS_IDLE: begin
            tag_in.fin = 1'b1;
            unique case (cmd)
               atd_pkg::CMD_CLEAR: tag_in.op = atd_pkg::OP_CLEAR;
               atd_pkg::CMD_LOAD: begin
                  tag_in.op = atd_pkg::OP_LOAD;
                  tag_in.slot = load_slot;
                  tag_in.ign = !map_ok;
                  tag_in.hit = map_ok && slot_ok;
               end
               atd_pkg::CMD_CHECK: tag_in.op = atd_pkg::OP_NOP;
               atd_pkg::CMD_NOP: tag_in.op = atd_pkg::OP_NOP;
               default: tag_in.op = atd_pkg::OP_NOP;
            endcase
            issue = accept && (cmd != atd_pkg::CMD_CHECK);
         end
         atd_pkg::FS_SCAN: begin
            issue = issue_ok;
            tag_in.op = atd_pkg::OP_SLOT;
            tag_in.slot = scan_ff;
            tag_in.hit = valid_ff[scan_ff];
            tag_in.fin = scan_last;
         end
         default: issue = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atd_pkg::FS_IDLE;
         scan_ff <= '0;
         outstanding_ff <= '0;
         valid_ff <= '0;
         tag_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tag_valid_ff <= issue;
         outstanding_ff <= outstanding_ff + atd_pkg::QCNT_W'(issue)
                           - atd_pkg::QCNT_W'(pop);
         if (accept && (cmd == atd_pkg::CMD_CHECK)) begin
            scan_ff <= '0;
         end else if ((state_ff == atd_pkg::FS_SCAN) && issue_ok) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (accept && (cmd == atd_pkg::CMD_CLEAR)) begin
            valid_ff <= '0;
         end else if (write_en) begin
            valid_ff[load_slot] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         tag_ff <= tag_in;
      end
      if (accept && (cmd == atd_pkg::CMD_CHECK)) begin
         point_x_ff <= req_data.coord_x;
         point_y_ff <= req_data.coord_y;
         point_z_ff <= req_data.coord_z;
      end
   end

   atd_ram #(
      .WIDTH($bits(atd_pkg::entry_type)),
      .DEPTH(atd_pkg::MAX_TRIGGERS)
   ) u_ram (
      .clock(clock),
      .write_enable(write_en),
      .write_address(load_slot),
      .write_data(entry_w),
      .read_address(scan_ff),
      .read_data(entry)
   );

   assign tag_valid = tag_valid_ff;
   assign tag = tag_ff;
   assign point_x = point_x_ff;
   assign point_y = point_y_ff;
   assign point_z = point_z_ff;

endmodule

FILE: rtl/core/atd_eval.sv
module atd_eval (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  atd_pkg::job_type in_job,
   input  atd_pkg::entry_type entry,
   input  logic signed [23:0] point_x,
   input  logic signed [23:0] point_y,
   input  logic signed [23:0] point_z,
   output logic out_valid,
   output atd_pkg::job_type out_job
);

   // stage 1: differences and sine lookup
   logic s1_v_ff;
   atd_pkg::job_type s1_job_ff, s1_job_in;
   logic [1:0] s1_kind_ff;
   logic signed [24:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic [22:0] s1_sx_ff, s1_sy_ff, s1_sz_ff;
   logic signed [15:0] s1_sin_ff, s1_cos_ff;
   logic [15:0] cos_u;
   logic signed [15:0] sin_in, cos_in;

   assign cos_u = entry.yaw + 16'd16384;

   always_comb begin
      if (entry.yaw == 16'd0) begin
         sin_in = 16'sd0;
         cos_in = 16'sd16384;
      end else begin
         sin_in = atd_pkg::SINE_ROM[entry.yaw[15 -: atd_pkg::SINE_W]];
         cos_in = atd_pkg::SINE_ROM[cos_u[15 -: atd_pkg::SINE_W]];
      end
   end

   always_comb begin
      s1_job_in = in_job;
      s1_job_in.id = entry.id;
   end

   // stage 2: products
   logic s2_v_ff;
   atd_pkg::job_type s2_job_ff;
   logic [1:0] s2_kind_ff;
   logic [47:0] s2_dxx_ff, s2_dyy_ff, s2_dzz_ff;
   logic [45:0] s2_rr_ff;
   logic signed [40:0] s2_dxc_ff, s2_dzs_ff, s2_dzc_ff, s2_dxs_ff;
   logic [24:0] s2_ady_ff;
   logic [22:0] s2_sx_ff, s2_sy_ff, s2_sz_ff;
   logic signed [49:0] dxx_in, dyy_in, dzz_in;

   assign dxx_in = s1_dx_ff * s1_dx_ff;
   assign dyy_in = s1_dy_ff * s1_dy_ff;
   assign dzz_in = s1_dz_ff * s1_dz_ff;

   // stage 3: sums
   logic s3_v_ff;
   atd_pkg::job_type s3_job_ff;
   logic [1:0] s3_kind_ff;
   logic [49:0] s3_sq_ff;
   logic [45:0] s3_rr_ff;
   logic signed [41:0] s3_rx_ff, s3_rz_ff;
   logic [24:0] s3_ady_ff;
   logic [22:0] s3_sx_ff, s3_sy_ff, s3_sz_ff;

   // stage 4: compares
   logic s4_v_ff;
   atd_pkg::job_type s4_job_ff, s4_job_in;
   logic [41:0] arx, arz;
   logic in_sphere, in_box, in_volume;

   assign arx = s3_rx_ff[41] ? 42'(-s3_rx_ff) : 42'(s3_rx_ff);
   assign arz = s3_rz_ff[41] ? 42'(-s3_rz_ff) : 42'(s3_rz_ff);
   assign in_sphere = s3_sq_ff <= 50'(s3_rr_ff);
   assign in_box = ({arx, 1'b0} <= 43'({s3_sx_ff, 14'd0}))
                   && ({s3_ady_ff, 1'b0} <= 26'(s3_sy_ff))
                   && ({arz, 1'b0} <= 43'({s3_sz_ff, 14'd0}));

   always_comb begin
      case (s3_kind_ff)
         atd_pkg::KIND_SPHERE: in_volume = in_sphere;
         atd_pkg::KIND_BOX: in_volume = in_box;
         default: in_volume = 1'b0;
      endcase
      s4_job_in = s3_job_ff;
      if (s3_job_ff.op == atd_pkg::OP_SLOT) begin
         s4_job_in.hit = s3_job_ff.hit && in_volume;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_job_ff <= s1_job_in;
      s1_kind_ff <= entry.kind;
      s1_dx_ff <= 25'(point_x) - 25'(entry.center_x);
      s1_dy_ff <= 25'(point_y) - 25'(entry.center_y);
      s1_dz_ff <= 25'(point_z) - 25'(entry.center_z);
      s1_sx_ff <= entry.size_x;
      s1_sy_ff <= entry.size_y;
      s1_sz_ff <= entry.size_z;
      s1_sin_ff <= sin_in;
      s1_cos_ff <= cos_in;

      s2_job_ff <= s1_job_ff;
      s2_kind_ff <= s1_kind_ff;
      s2_dxx_ff <= dxx_in[47:0];
      s2_dyy_ff <= dyy_in[47:0];
      s2_dzz_ff <= dzz_in[47:0];
      s2_rr_ff <= s1_sx_ff * s1_sx_ff;
      s2_dxc_ff <= s1_dx_ff * s1_cos_ff;
      s2_dzs_ff <= s1_dz_ff * s1_sin_ff;
      s2_dzc_ff <= s1_dz_ff * s1_cos_ff;
      s2_dxs_ff <= s1_dx_ff * s1_sin_ff;
      s2_ady_ff <= s1_dy_ff[24] ? 25'(-s1_dy_ff) : 25'(s1_dy_ff);
      s2_sx_ff <= s1_sx_ff;
      s2_sy_ff <= s1_sy_ff;
      s2_sz_ff <= s1_sz_ff;

      s3_job_ff <= s2_job_ff;
      s3_kind_ff <= s2_kind_ff;
      s3_sq_ff <= 50'(s2_dxx_ff) + 50'(s2_dyy_ff) + 50'(s2_dzz_ff);
      s3_rr_ff <= s2_rr_ff;
      s3_rx_ff <= 42'(s2_dxc_ff) + 42'(s2_dzs_ff);
      s3_rz_ff <= 42'(s2_dzc_ff) - 42'(s2_dxs_ff);
      s3_ady_ff <= s2_ady_ff;
      s3_sx_ff <= s2_sx_ff;
      s3_sy_ff <= s2_sy_ff;
      s3_sz_ff <= s2_sz_ff;

      s4_job_ff <= s4_job_in;
   end

   assign out_valid = s4_v_ff;
   assign out_job = s4_job_ff;

endmodule

FILE: rtl/core/atd_queue.sv
module atd_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  atd_pkg::job_type push_data,
   input  logic pop,
   output logic head_valid,
   output atd_pkg::job_type head_data
);

   atd_pkg::job_type mem_ff [atd_pkg::QDEPTH];
   logic [atd_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [atd_pkg::QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + atd_pkg::QCNT_W'(push) - atd_pkg::QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_data = mem_ff[rd_ff];

endmodule

FILE: rtl/core/atd_back.sv
module atd_back (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  atd_pkg::job_type head_data,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output atd_pkg::rsp_type rsp_data
);

   logic [atd_pkg::MAX_TRIGGERS-1:0] marks_ff;
   logic flush_ff;
   logic pend_v_ff;
   logic [31:0] pend_id_ff;
   logic [atd_pkg::CNT_W-1:0] cnt_ff;
   logic rsp_valid_ff;
   atd_pkg::rsp_type rsp_ff, rsp_in;
   logic out_free, emit, entered;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign entered = (head_data.op == atd_pkg::OP_SLOT) && head_data.hit
                    && !marks_ff[head_data.slot]
                    && (cnt_ff < atd_pkg::CNT_W'(atd_pkg::RESULT_CAP));

   always_comb begin
      emit = 1'b0;
      pop = 1'b0;
      rsp_in = '0;
      if (flush_ff) begin
         // close the check: pending hit goes out last, or a bare ack
         emit = 1'b1;
         rsp_in.last = 1'b1;
         if (pend_v_ff) begin
            rsp_in.entered_id = pend_id_ff;
            rsp_in.found = 1'b1;
         end
      end else if (head_valid) begin
         if (head_data.op == atd_pkg::OP_SLOT) begin
            emit = entered && pend_v_ff;
            rsp_in.entered_id = pend_id_ff;
            rsp_in.found = 1'b1;
         end else begin
            emit = 1'b1;
            rsp_in.load_ignored = head_data.ign;
            rsp_in.last = 1'b1;
         end
         pop = !emit || out_free;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
         flush_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (flush_ff && out_free) begin
            flush_ff <= 1'b0;
            pend_v_ff <= 1'b0;
            cnt_ff <= '0;
         end
         if (pop) begin
            case (head_data.op)
               atd_pkg::OP_CLEAR: marks_ff <= '0;
               atd_pkg::OP_LOAD: begin
                  if (head_data.hit) begin
                     marks_ff[head_data.slot] <= 1'b0;
                  end
               end
               atd_pkg::OP_SLOT: begin
                  marks_ff[head_data.slot] <= head_data.hit;
                  if (entered) begin
                     pend_v_ff <= 1'b1;
                     cnt_ff <= cnt_ff + 1'b1;
                  end
                  if (head_data.fin) begin
                     flush_ff <= 1'b1;
                  end
               end
               default: marks_ff <= marks_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit && out_free) begin
         rsp_ff <= rsp_in;
      end
      if (pop && entered) begin
         pend_id_ff <= head_data.id;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/core/area_trigger_enter_detector.sv
// channel   direction  handshake              word
// req_      in         req_valid / req_ready  atd_pkg::req_type (command + trigger/point)
// rsp_      out        rsp_valid / rsp_ready  atd_pkg::rsp_type (entered id, flags, last)
// csr_      in         csr_write_enable       32-bit active map, written at once
//
// Clear, load and idle commands each enter the front as one job, which passes the
// geometry stages and the job queue to the back. A check walks every table slot
// through the entry RAM read port, one slot a cycle while the job queue has credit.
// Reset is synchronous; slot valid bits and inside marks clear at once, no sweep.
// A stalled rsp_ready fills the eight-deep job queue, then holds the slot walk.
module area_trigger_enter_detector (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  atd_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output atd_pkg::rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic [31:0] active_map_ff;
   logic pop;
   logic tag_valid;
   atd_pkg::job_type tag;
   atd_pkg::entry_type entry;
   logic signed [23:0] point_x, point_y, point_z;
   logic eval_valid;
   atd_pkg::job_type eval_job;
   logic head_valid;
   atd_pkg::job_type head_data;

   // active map register; write it only while the block is idle (the block does not enforce this)
   always_ff @(posedge clock) begin
      if (reset) begin
         active_map_ff <= '0;
      end else if (csr_write_enable) begin
         active_map_ff <= csr_write_data;
      end
   end

   // front: decode, table writes, slot walk and credit against the queue
   atd_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .active_map(active_map_ff),
      .pop(pop),
      .tag_valid(tag_valid),
      .tag(tag),
      .entry(entry),
      .point_x(point_x),
      .point_y(point_y),
      .point_z(point_z)
   );

   // geometry: four stages, never stalls; the front's credit keeps it from overrunning
   atd_eval u_eval (
      .clock(clock),
      .reset(reset),
      .in_valid(tag_valid),
      .in_job(tag),
      .entry(entry),
      .point_x(point_x),
      .point_y(point_y),
      .point_z(point_z),
      .out_valid(eval_valid),
      .out_job(eval_job)
   );

   atd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(eval_valid),
      .push_data(eval_job),
      .pop(pop),
      .head_valid(head_valid),
      .head_data(head_data)
   );

   // back: inside marks, enter detection, result words
   atd_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_data(head_data),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

FILE: rtl/core/atd_checker.sv
module atd_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  atd_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  atd_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word dropped or changed while stalled");

   a_found_not_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.found && rsp_data.load_ignored))
      else $error("entered word flagged as ignored load");

   a_ack_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.last && (rsp_data.entered_id == 32'd0))
      else $error("acknowledge word not last or carries an id");

   a_check_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.command == atd_pkg::CMD_CHECK) |=> !req_ready)
      else $error("new word taken while a check walk starts");

endmodule

bind area_trigger_enter_detector atd_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);

FILE: verif/tb_top.sv
module tb_top;

   // clock and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   atd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   atd_pkg::rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   area_trigger_enter_detector uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 0;
   end

   // shadow copy of the trigger table and the active map
   logic [31:0] map_now;
   bit slot_on [64];
   bit slot_in [64];
   logic [31:0] trig_id [64];
   logic [1:0] trig_kind [64];
   logic signed [23:0] ctr_x [64];
   logic signed [23:0] ctr_y [64];
   logic signed [23:0] ctr_z [64];
   logic [22:0] dim_x [64];
   logic [22:0] dim_y [64];
   logic [22:0] dim_z [64];
   logic [15:0] trig_yaw [64];
   int sine_tab [1024];

   atd_pkg::rsp_type pending_words [$];
   int errors = 0;
   bit quick = 0;      // no idling on either side
   bit hold_rsp = 0;   // ask the receiver for one long hold-off

   typedef struct {
      atd_pkg::req_type r;
      bit typed;
      atd_pkg::rsp_type e;
   } row_type;
   row_type rows [$];

   // Q1.14 sine, Taylor series in Q30, folded into the first quadrant
   task automatic fill_sine();
      longint unsigned a, x2, term;
      longint s;
      bit neg;
      for (int k = 0; k < 1024; k++) begin
         a = (64'd6746518852 * 64'(k)) / 64'd1024;
         neg = 0;
         if (a >= 64'd3373259426) begin
            a = a - 64'd3373259426;
            neg = 1;
         end
         if (a > 64'd1686629713) a = 64'd3373259426 - a;
         x2 = (a * a) >> 30;
         term = a;
         s = longint'(a);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) s = s - longint'(term);
            else s = s + longint'(term);
         end
         if (s < 0) s = 0;
         s = longint'((64'(s) + 64'd32768) >> 16);
         sine_tab[k] = neg ? -int'(s) : int'(s);
      end
   endtask

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic bit holds_point(int i, logic signed [23:0] px,
                                      logic signed [23:0] py, logic signed [23:0] pz);
      longint dx, dy, dz, rx, rz, sn, cs, rad;
      int u;
      dx = longint'(px) - longint'(ctr_x[i]);
      dy = longint'(py) - longint'(ctr_y[i]);
      dz = longint'(pz) - longint'(ctr_z[i]);
      if (trig_kind[i] == atd_pkg::KIND_SPHERE) begin
         rad = longint'({41'b0, dim_x[i]});
         return dx * dx + dy * dy + dz * dz <= rad * rad;
      end
      if (trig_kind[i] == atd_pkg::KIND_BOX) begin
         u = int'(trig_yaw[i]);
         sn = sine_tab[u >> 6];
         cs = sine_tab[((u + 16384) & 16'hFFFF) >> 6];
         if (u == 0) begin
            rx = dx * 16384;
            rz = dz * 16384;
         end else begin
            rx = dx * cs + dz * sn;
            rz = dz * cs - dx * sn;
         end
         return 2 * mag(rx) <= (longint'({41'b0, dim_x[i]}) << 14) &&
                2 * mag(dy) <= longint'({41'b0, dim_y[i]}) &&
                2 * mag(rz) <= (longint'({41'b0, dim_z[i]}) << 14);
      end
      return 0;
   endfunction

   // append one expected word at the tail
   function automatic void queue_word(atd_pkg::rsp_type w);
      pending_words = {pending_words, w};
   endfunction

   // advance the shadow table by one command and queue the words it must produce
   function automatic void detect_entries(atd_pkg::req_type r);
      atd_pkg::rsp_type w;
      int n;
      bit now;
      w = '0;
      w.last = 1'b1;
      case (atd_pkg::cmd_type'(r.command))
         atd_pkg::CMD_CLEAR: begin
            for (int i = 0; i < 64; i++) begin
               slot_on[i] = 0;
               slot_in[i] = 0;
            end
            queue_word(w);
         end
         atd_pkg::CMD_LOAD: begin
            if (r.map_id != map_now) begin
               w.load_ignored = 1'b1;
            end else begin
               slot_on[r.slot] = 1;
               slot_in[r.slot] = 0;
               trig_id[r.slot] = r.trigger_id;
               trig_kind[r.slot] = r.kind;
               ctr_x[r.slot] = r.coord_x;
               ctr_y[r.slot] = r.coord_y;
               ctr_z[r.slot] = r.coord_z;
               dim_x[r.slot] = r.extent_x;
               dim_y[r.slot] = r.extent_y;
               dim_z[r.slot] = r.extent_z;
               trig_yaw[r.slot] = r.yaw_angle;
            end
            queue_word(w);
         end
         atd_pkg::CMD_CHECK: begin
            n = 0;
            for (int i = 0; i < 64; i++) begin
               now = slot_on[i] && holds_point(i, r.coord_x, r.coord_y, r.coord_z);
               if (now && !slot_in[i]) begin
                  w = '0;
                  w.entered_id = trig_id[i];
                  w.found = 1'b1;
                  queue_word(w);
                  n++;
               end
               slot_in[i] = now;
            end
            if (n == 0) begin
               w = '0;
               w.last = 1'b1;
               queue_word(w);
            end else begin
               pending_words[pending_words.size() - 1].last = 1'b1;
            end
         end
         default: queue_word(w);
      endcase
   endfunction

   function automatic atd_pkg::req_type mk(atd_pkg::cmd_type c, int sl, logic [31:0] id,
                                           logic [31:0] mp, logic [1:0] kd,
                                           logic [23:0] x, logic [23:0] y,
                                           logic [23:0] z, logic [22:0] ex,
                                           logic [22:0] ey, logic [22:0] ez,
                                           logic [15:0] yw);
      atd_pkg::req_type r;
      r.command = c;
      r.slot = 6'(sl);
      r.trigger_id = id;
      r.map_id = mp;
      r.kind = kd;
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      r.extent_x = ex;
      r.extent_y = ey;
      r.extent_z = ez;
      r.yaw_angle = yw;
      return r;
   endfunction

   function automatic void add_row(atd_pkg::req_type r, bit typed = 0, bit ign = 0);
      row_type rw;
      rw.r = r;
      rw.typed = typed;
      rw.e = '0;
      rw.e.load_ignored = ign;
      rw.e.last = 1'b1;
      rows = {rows, rw};
   endfunction

   // offer one word after a random gap; hold it until accepted, then predict
   task automatic send(atd_pkg::req_type r, bit typed = 0, atd_pkg::rsp_type e = '0);
      int gap;
      int prior_count;
      gap = quick ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      prior_count = pending_words.size();
      detect_entries(r);
      if (typed) begin
         while (pending_words.size() > prior_count) void'(pending_words.pop_back());
         queue_word(e);
      end
   endtask

   // drain everything in flight, then write the active map
   task automatic write_map(logic [31:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      map_now = v;
   endtask

   function automatic logic [23:0] near(logic [23:0] c, int spread);
      return c + 24'($signed($urandom_range(0, 2 * spread)) - spread);
   endfunction

   function automatic atd_pkg::req_type random_word();
      atd_pkg::req_type r;
      int p;
      int sl;
      r = '0;
      r.trigger_id = $urandom();
      r.slot = 6'($urandom_range(0, 63));
      r.coord_x = 24'($urandom());
      r.coord_y = 24'($urandom());
      r.coord_z = 24'($urandom());
      r.extent_x = 23'($urandom());
      r.extent_y = 23'($urandom());
      r.extent_z = 23'($urandom());
      r.yaw_angle = 16'($urandom());
      r.kind = 2'($urandom_range(0, 3));
      p = $urandom_range(0, 99);
      if (p < 2) begin
         r.command = atd_pkg::CMD_CLEAR;
      end else if (p < 5) begin
         r.command = atd_pkg::CMD_NOP;
      end else if (p < 42) begin
         r.command = atd_pkg::CMD_LOAD;
         r.map_id = ($urandom_range(0, 9) == 0) ? $urandom() : map_now;
         if ($urandom_range(0, 9) < 8) r.kind = 2'($urandom_range(1, 2));
         if ($urandom_range(0, 9) < 7) begin
            r.coord_x = near('0, 4000);
            r.coord_y = near('0, 4000);
            r.coord_z = near('0, 4000);
         end
         if ($urandom_range(0, 9) < 8) begin
            r.extent_x = 23'($urandom_range(0, 3000));
            r.extent_y = 23'($urandom_range(0, 3000));
            r.extent_z = 23'($urandom_range(0, 3000));
         end
         if ($urandom_range(0, 4) == 0) r.yaw_angle = '0;
      end else begin
         r.command = atd_pkg::CMD_CHECK;
         sl = $urandom_range(0, 63);
         if ($urandom_range(0, 9) < 6 && slot_on[sl]) begin
            r.coord_x = near(ctr_x[sl], 2000);
            r.coord_y = near(ctr_y[sl], 2000);
            r.coord_z = near(ctr_z[sl], 2000);
         end else if ($urandom_range(0, 1) == 0) begin
            r.coord_x = near('0, 4000);
            r.coord_y = near('0, 4000);
            r.coord_z = near('0, 4000);
         end
      end
      return r;
   endfunction

   // receiver: random hold-off per word, one long hold-off on request
   initial begin
      int w;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            w = 400;
            hold_rsp = 0;
         end else begin
            w = quick ? 0 : $urandom_range(0, 5);
         end
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare every accepted word with the oldest expectation
   always @(posedge clock) begin
      atd_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, rsp_data);
            errors++;
         end else begin
            e = pending_words.pop_front();
            if (rsp_data.entered_id !== e.entered_id) begin
               $display("%0t: entered_id expected %h actual %h", $time, e.entered_id,
                        rsp_data.entered_id);
               errors++;
            end
            if (rsp_data.found !== e.found) begin
               $display("%0t: found expected %b actual %b", $time, e.found, rsp_data.found);
               errors++;
            end
            if (rsp_data.load_ignored !== e.load_ignored) begin
               $display("%0t: load_ignored expected %b actual %b", $time, e.load_ignored,
                        rsp_data.load_ignored);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $display("%0t: last expected %b actual %b", $time, e.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   initial begin
      logic [31:0] maps [4];
      fill_sine();
      map_now = '0;
      for (int i = 0; i < 64; i++) begin
         slot_on[i] = 0;
         slot_in[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, wrong map, extremes, kinds that never match,
      // reload, shared ids, clear and idle commands
      add_row(mk(atd_pkg::CMD_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
      add_row(mk(atd_pkg::CMD_LOAD, 0, 1, 5, atd_pkg::KIND_SPHERE, 0, 0, 0, 16, 0, 0, 0),
              1, 1);
      add_row(mk(atd_pkg::CMD_LOAD, 0, 32'hFFFFFFFF, 0, atd_pkg::KIND_SPHERE, 0, 0, 0, 16,
                 0, 0, 0), 1);
      add_row(mk(atd_pkg::CMD_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk(atd_pkg::CMD_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
      add_row(mk(atd_pkg::CMD_LOAD, 63, 32'h63, 0, atd_pkg::KIND_BOX, 24'h7FFFFF,
                 24'h7FFFFF, 24'h7FFFFF, 64, 64, 64, 0), 1);
      add_row(mk(atd_pkg::CMD_CHECK, 0, 0, 0, 0, 24'h7FFFE0, 24'h7FFFFF, 24'h7FFFFF,
                 0, 0, 0, 0));
      add_row(mk(atd_pkg::CMD_LOAD, 1, 32'h1, 0, atd_pkg::KIND_BOX, 24'h800000,
                 24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'h8000), 1);
      add_row(mk(atd_pkg::CMD_CHECK, 0, 0, 0, 0, 24'h800000, 24'h800000, 24'h800000,
                 0, 0, 0, 0));
      add_row(mk(atd_pkg::CMD_LOAD, 2, 32'h2, 0, 2'd0, 0, 0, 0, 23'h7FFFFF, 23'h7FFFFF,
                 23'h7FFFFF, 0), 1);
      add_row(mk(atd_pkg::CMD_LOAD, 3, 32'h3, 0, 2'd3, 0, 0, 0, 23'h7FFFFF, 23'h7FFFFF,
                 23'h7FFFFF, 0), 1);
      add_row(mk(atd_pkg::CMD_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk(atd_pkg::CMD_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
      add_row(mk(atd_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
      add_row(mk(atd_pkg::CMD_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
      add_row(mk(atd_pkg::CMD_LOAD, 5, 32'hAB, 0, atd_pkg::KIND_SPHERE, 0, 0, 0,
                 23'h7FFFFF, 0, 0, 0), 1);
      add_row(mk(atd_pkg::CMD_LOAD, 6, 32'hAB, 0, atd_pkg::KIND_SPHERE, 0, 0, 0,
                 23'h7FFFFF, 0, 0, 0), 1);
      add_row(mk(atd_pkg::CMD_CHECK, 0, 0, 0, 0, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0, 0));
      add_row(mk(atd_pkg::CMD_LOAD, 5, 32'hAB, 0, atd_pkg::KIND_SPHERE, 0, 0, 0,
                 23'h7FFFFF, 0, 0, 0), 1);
      add_row(mk(atd_pkg::CMD_CHECK, 0, 0, 0, 0, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0, 0));
      add_row(mk(atd_pkg::CMD_LOAD, 7, 32'h77, 0, atd_pkg::KIND_BOX, 0, 0, 0, 32, 100,
                 4000, 16'h4000), 1);
      add_row(mk(atd_pkg::CMD_CHECK, 0, 0, 0, 0, 1500, 40, 10, 0, 0, 0, 0));
      add_row(mk(atd_pkg::CMD_CHECK, 0, 0, 0, 0, 10, 40, 1500, 0, 0, 0, 0));
      foreach (rows[i]) send(rows[i].r, rows[i].typed, rows[i].e);

      // random phases, each under its own active map
      maps[0] = 32'hFFFFFFFF;
      maps[1] = $urandom();
      maps[2] = 32'h0;
      maps[3] = $urandom();
      for (int ph = 0; ph < 4; ph++) begin
         write_map(maps[ph]);
         quick = (ph == 2);
         if (ph == 1) hold_rsp = 1;
         for (int k = 0; k < 115; k++) send(random_word());
      end
      req_valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
